@@ hw/rtl/envelope_gated_gain_fader_unit_macros.svh @@
// Assertion helpers shared by the fader RTL.
// Each helper samples on i_clk and is disabled while i_rst_n is low.
`ifndef ENVELOPE_GATED_GAIN_FADER_UNIT_MACROS_SVH
`define ENVELOPE_GATED_GAIN_FADER_UNIT_MACROS_SVH

// Same-cycle implication
`define EGF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define EGF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/egf_pkg.sv @@
package egf_pkg;

    // Field widths
    localparam int DATA_W    = 24;
    localparam int COEF_W    = 17;
    localparam int COEF_FRAC = 16;
    localparam int CLIP_W    = DATA_W + 1;
    localparam int PROD_W    = COEF_W + DATA_W;
    localparam int QUOT_W    = DATA_W - 1;

    // APB port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Serial unit lengths
    localparam int MUL_STEPS = COEF_W;
    localparam int DIV_STEPS = QUOT_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Fixed-point constants
    localparam logic [DATA_W-1:0] UNITY      = DATA_W'(1) << QUOT_W;
    localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1) << COEF_FRAC;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_FRAC - 1);

    // Register reset values
    localparam logic [COEF_W-1:0] ATTACK_RST    = COEF_W'(167);
    localparam logic [COEF_W-1:0] RELEASE_RST   = COEF_W'(167);
    localparam logic [DATA_W-1:0] THRESHOLD_RST = DATA_W'(839);
    localparam logic [DATA_W-1:0] CLIP_STEP_RST = DATA_W'(3495);

    // Register map, word index
    typedef enum logic [1:0] {
        REG_ATTACK    = 2'd0,
        REG_RELEASE   = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_CLIP_STEP = 2'd3
    } t_reg_idx;

    // Fade machine
    typedef enum logic [1:0] {
        FADE_CLOSED = 2'd0,
        FADE_FADING = 2'd1,
        FADE_OPENED = 2'd2
    } t_fade;

    // Sample sequencer
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL,
        SEQ_UPD,
        SEQ_DIV,
        SEQ_OUT
    } t_seq;

    // Configuration bundle from the register block
    typedef struct packed {
        logic [COEF_W-1:0] attack_coef;
        logic [COEF_W-1:0] release_coef;
        logic [DATA_W-1:0] threshold;
        logic [DATA_W-1:0] clip_step;
    } t_cfg;

endpackage

@@ hw/rtl/egf_stream_if.sv @@
interface egf_sample_if;
    logic                              valid;
    logic                              ready;
    logic signed [egf_pkg::DATA_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface egf_gain_if;
    logic                       valid;
    logic                       ready;
    logic [egf_pkg::DATA_W-1:0] gain;

    modport source (output valid, output gain, input ready);
    modport sink   (input valid, input gain, output ready);
endinterface

@@ hw/rtl/egf_regs.sv @@
module egf_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [egf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [egf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [egf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output egf_pkg::t_cfg                     o_cfg
);

    egf_pkg::t_cfg    r_cfg;
    egf_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = egf_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_coef  <= egf_pkg::ATTACK_RST;
            r_cfg.release_coef <= egf_pkg::RELEASE_RST;
            r_cfg.threshold    <= egf_pkg::THRESHOLD_RST;
            r_cfg.clip_step    <= egf_pkg::CLIP_STEP_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                egf_pkg::REG_ATTACK:    r_cfg.attack_coef  <= pwdata[egf_pkg::COEF_W-1:0];
                egf_pkg::REG_RELEASE:   r_cfg.release_coef <= pwdata[egf_pkg::COEF_W-1:0];
                egf_pkg::REG_THRESHOLD: r_cfg.threshold    <= pwdata[egf_pkg::DATA_W-1:0];
                egf_pkg::REG_CLIP_STEP: r_cfg.clip_step    <= pwdata[egf_pkg::DATA_W-1:0];
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            egf_pkg::REG_ATTACK:    prdata = egf_pkg::APB_DATA_W'(r_cfg.attack_coef);
            egf_pkg::REG_RELEASE:   prdata = egf_pkg::APB_DATA_W'(r_cfg.release_coef);
            egf_pkg::REG_THRESHOLD: prdata = egf_pkg::APB_DATA_W'(r_cfg.threshold);
            egf_pkg::REG_CLIP_STEP: prdata = egf_pkg::APB_DATA_W'(r_cfg.clip_step);
        endcase
    end

endmodule

@@ hw/rtl/egf_mul.sv @@
module egf_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [egf_pkg::COEF_W-1:0]      i_coef,
    input  logic [egf_pkg::DATA_W-1:0]      i_mult,
    output logic                            o_done,
    output logic [egf_pkg::PROD_W-1:0]      o_product
);

    logic                            r_busy;
    logic                            r_done;
    logic [egf_pkg::MUL_CNT_W-1:0]   r_cnt;
    logic [egf_pkg::COEF_W-1:0]      r_coef;
    logic [egf_pkg::DATA_W-1:0]      r_mult;
    logic [egf_pkg::PROD_W-1:0]      r_acc;
    logic [egf_pkg::PROD_W-1:0]      n_acc;

    // Shift-add on the coefficient, most significant bit first
    always_comb begin
        n_acc = {r_acc[egf_pkg::PROD_W-2:0], 1'b0};
        if (r_coef[egf_pkg::COEF_W-1]) begin
            n_acc = n_acc + egf_pkg::PROD_W'(r_mult);
        end
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= egf_pkg::MUL_CNT_W'(egf_pkg::MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - egf_pkg::MUL_CNT_W'(1);
                if (r_cnt == egf_pkg::MUL_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand shift register and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_coef <= i_coef;
            r_mult <= i_mult;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_coef <= {r_coef[egf_pkg::COEF_W-2:0], 1'b0};
            r_acc  <= n_acc;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

@@ hw/rtl/egf_div.sv @@
module egf_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [egf_pkg::DATA_W-1:0]      i_dividend,
    input  logic [egf_pkg::DATA_W-1:0]      i_divisor,
    output logic                            o_done,
    output logic [egf_pkg::QUOT_W-1:0]      o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [egf_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [egf_pkg::DATA_W-1:0]      r_rem;
    logic [egf_pkg::DATA_W-1:0]      r_div;
    logic [egf_pkg::QUOT_W-1:0]      r_quot;
    logic [egf_pkg::DATA_W:0]        w_shift;
    logic [egf_pkg::DATA_W:0]        w_diff;
    logic                            w_fit;

    // Restoring step: double the remainder, subtract the divisor if it fits
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fit   = w_shift >= {1'b0, r_div};

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= egf_pkg::DIV_CNT_W'(egf_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - egf_pkg::DIV_CNT_W'(1);
                if (r_cnt == egf_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[egf_pkg::DATA_W-1:0] : w_shift[egf_pkg::DATA_W-1:0];
            r_quot <= {r_quot[egf_pkg::QUOT_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

@@ hw/rtl/envelope_gated_gain_fader_unit.sv @@
// Envelope-gated gain fader. Each accepted signed Q1.23 sample updates an
// envelope of its magnitude (attack or release coefficient, Q1.16) and yields
// one unsigned Q1.23 gain word. The gain is unity when no fade is computed;
// a fading gain below unity comes from the restoring divider. The bit-serial
// envelope multiplier (one coefficient bit per cycle) and the restoring divider
// (one quotient bit per cycle) work in turn; one sample is in flight at a time,
// and the next sample is taken while the previous gain still waits in the output
// register. Configuration is written over APB at byte addresses 0, 4, 8, 12
// (attack, release, threshold, clip step); the user must write it only while no
// sample is in flight, as the block itself does not enforce this.
`include "envelope_gated_gain_fader_unit_macros.svh"

module envelope_gated_gain_fader_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    egf_sample_if.sink                        i_sample_if,
    egf_gain_if.source                        o_gain_if,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [egf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [egf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [egf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    egf_pkg::t_cfg                    w_cfg;

    egf_pkg::t_seq                    r_seq;
    egf_pkg::t_seq                    n_seq;
    egf_pkg::t_fade                   r_fade;
    egf_pkg::t_fade                   n_fade;

    logic [egf_pkg::DATA_W-1:0]       r_env;
    logic [egf_pkg::CLIP_W-1:0]       r_clip;
    logic [egf_pkg::CLIP_W-1:0]       n_clip;
    logic                             r_up;
    logic [egf_pkg::DATA_W-1:0]       r_res;
    logic                             r_out_valid;
    logic [egf_pkg::DATA_W-1:0]       r_out_gain;

    logic                             w_in_fire;
    logic                             w_in_ready;
    logic                             w_upd_en;
    logic                             w_div_start;
    logic                             w_out_load;
    logic                             w_need_div;

    logic [egf_pkg::DATA_W-1:0]       w_raw;
    logic [egf_pkg::DATA_W-1:0]       w_mag;
    logic                             w_up;
    logic [egf_pkg::DATA_W-1:0]       w_diff;
    logic [egf_pkg::COEF_W-1:0]       w_att;
    logic [egf_pkg::COEF_W-1:0]       w_rel;
    logic [egf_pkg::COEF_W-1:0]       w_coef;
    logic [egf_pkg::DATA_W-1:0]       w_thr;

    logic                             w_mul_done;
    logic [egf_pkg::PROD_W-1:0]       w_product;
    logic [egf_pkg::PROD_W-1:0]       w_rnd;
    logic [egf_pkg::DATA_W-1:0]       w_step;
    logic [egf_pkg::DATA_W:0]         w_env_sum;
    logic [egf_pkg::DATA_W-1:0]       w_env_new;
    logic [egf_pkg::CLIP_W-1:0]       w_clip_add;

    logic                             w_div_done;
    logic [egf_pkg::QUOT_W-1:0]       w_quot;

    // Configuration registers
    egf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Clamp coefficients and threshold to 1.0
    assign w_att = (w_cfg.attack_coef  > egf_pkg::COEF_ONE) ? egf_pkg::COEF_ONE
                                                           : w_cfg.attack_coef;
    assign w_rel = (w_cfg.release_coef > egf_pkg::COEF_ONE) ? egf_pkg::COEF_ONE
                                                           : w_cfg.release_coef;
    assign w_thr = (w_cfg.threshold > egf_pkg::UNITY) ? egf_pkg::UNITY : w_cfg.threshold;

    // Magnitude and envelope difference; the most negative sample maps to unity
    assign w_raw  = i_sample_if.sample;
    assign w_mag  = w_raw[egf_pkg::DATA_W-1] ? (~w_raw + egf_pkg::DATA_W'(1)) : w_raw;
    assign w_up   = w_mag > r_env;
    assign w_diff = w_up ? (w_mag - r_env) : (r_env - w_mag);
    assign w_coef = w_up ? w_att : w_rel;

    assign w_in_fire         = i_sample_if.valid && w_in_ready;
    assign i_sample_if.ready = w_in_ready;

    egf_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_in_fire),
        .i_coef    (w_coef),
        .i_mult    (w_diff),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    // Rounded envelope step and new envelope
    assign w_rnd     = w_product + egf_pkg::ROUND_HALF;
    assign w_step    = w_rnd[egf_pkg::COEF_FRAC +: egf_pkg::DATA_W];
    assign w_env_sum = {1'b0, r_env} + {1'b0, w_step};
    always_comb begin
        if (r_up) begin
            w_env_new = (w_env_sum > {1'b0, egf_pkg::UNITY}) ? egf_pkg::UNITY
                                                              : w_env_sum[egf_pkg::DATA_W-1:0];
        end else begin
            w_env_new = r_env - w_step;
        end
    end

    // Fade machine next state on the new envelope
    assign w_clip_add = r_clip + egf_pkg::CLIP_W'(w_cfg.clip_step);
    always_comb begin
        n_fade     = r_fade;
        n_clip     = r_clip;
        w_need_div = 1'b0;
        unique case (r_fade)
            egf_pkg::FADE_CLOSED: begin
                if (w_env_new >= w_thr) begin
                    n_clip = egf_pkg::CLIP_W'(w_thr);
                    n_fade = egf_pkg::FADE_FADING;
                end
            end
            egf_pkg::FADE_FADING: begin
                w_need_div = egf_pkg::CLIP_W'(w_env_new) > r_clip;
                if (w_env_new < w_thr) begin
                    n_fade = egf_pkg::FADE_CLOSED;
                end else begin
                    n_clip = w_clip_add;
                    if (w_clip_add >= egf_pkg::CLIP_W'(egf_pkg::UNITY)) begin
                        n_fade = egf_pkg::FADE_OPENED;
                    end
                end
            end
            egf_pkg::FADE_OPENED: begin
                if (w_env_new < w_thr) begin
                    n_fade = egf_pkg::FADE_CLOSED;
                end
            end
            default: begin
                n_fade = r_fade;
            end
        endcase
    end

    egf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_clip[egf_pkg::DATA_W-1:0]),
        .i_divisor  (w_env_new),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // Sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            egf_pkg::SEQ_IDLE: if (w_in_fire)  n_seq = egf_pkg::SEQ_MUL;
            egf_pkg::SEQ_MUL:  if (w_mul_done) n_seq = egf_pkg::SEQ_UPD;
            egf_pkg::SEQ_UPD:  n_seq = w_need_div ? egf_pkg::SEQ_DIV : egf_pkg::SEQ_OUT;
            egf_pkg::SEQ_DIV:  if (w_div_done) n_seq = egf_pkg::SEQ_OUT;
            egf_pkg::SEQ_OUT:  if (w_out_load) n_seq = egf_pkg::SEQ_IDLE;
            default:           n_seq = egf_pkg::SEQ_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        w_in_ready  = r_seq == egf_pkg::SEQ_IDLE;
        w_upd_en    = r_seq == egf_pkg::SEQ_UPD;
        w_div_start = w_upd_en && w_need_div;
        w_out_load  = (r_seq == egf_pkg::SEQ_OUT) && (!r_out_valid || o_gain_if.ready);
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= egf_pkg::SEQ_IDLE;
            r_fade      <= egf_pkg::FADE_CLOSED;
            r_env       <= '0;
            r_clip      <= egf_pkg::CLIP_W'(egf_pkg::UNITY);
            r_out_valid <= 1'b0;
        end else begin
            r_seq <= n_seq;
            if (w_upd_en) begin
                r_fade <= n_fade;
                r_clip <= n_clip;
                r_env  <= w_env_new;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_gain_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold direction, result and output word
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_up <= w_up;
        end
        if (w_upd_en && !w_need_div) begin
            r_res <= egf_pkg::UNITY;
        end else if (w_div_done) begin
            r_res <= egf_pkg::DATA_W'(w_quot);
        end
        if (w_out_load) begin
            r_out_gain <= r_res;
        end
    end

    assign o_gain_if.valid = r_out_valid;
    assign o_gain_if.gain  = r_out_gain;

    `EGF_ASSERT_IMPL(a_env_range, 1'b1, r_env <= egf_pkg::UNITY, "envelope above unity")
    `EGF_ASSERT_IMPL(a_clip_fading, r_fade == egf_pkg::FADE_FADING, r_clip <= egf_pkg::CLIP_W'(egf_pkg::UNITY), "clip above unity while fading")
    `EGF_ASSERT_IMPL(a_div_in_seq, w_div_done, r_seq == egf_pkg::SEQ_DIV, "divider finished outside divide phase")
    `EGF_ASSERT_NEXT(a_accept_mul, w_in_fire, r_seq == egf_pkg::SEQ_MUL, "accepted sample did not start multiply")

endmodule

@@ tb/tb_top.sv @@
module tb_top;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [egf_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [egf_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [egf_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    egf_sample_if smp_if();
    egf_gain_if   gain_if();

    envelope_gated_gain_fader_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample_if (smp_if),
        .o_gain_if   (gain_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Shadow copy of the configuration and the fader state
    logic [egf_pkg::COEF_W-1:0] cf_attack  = egf_pkg::ATTACK_RST;
    logic [egf_pkg::COEF_W-1:0] cf_release = egf_pkg::RELEASE_RST;
    logic [egf_pkg::DATA_W-1:0] cf_thr     = egf_pkg::THRESHOLD_RST;
    logic [egf_pkg::DATA_W-1:0] cf_step    = egf_pkg::CLIP_STEP_RST;
    logic [egf_pkg::DATA_W-1:0] env_lvl    = '0;
    logic [egf_pkg::CLIP_W-1:0] clip_lvl   = egf_pkg::CLIP_W'(egf_pkg::UNITY);
    egf_pkg::t_fade             fade_st    = egf_pkg::FADE_CLOSED;

    logic [egf_pkg::DATA_W-1:0] pending_gains[$];
    logic [egf_pkg::DATA_W-1:0] oldest_gain;

    int err_cnt      = 0;
    int gains_seen   = 0;
    int cycle_cnt    = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_req  = 0;
    int rx_hold_left = 0;

    always #10 clk = ~clk;

    task automatic report_error(input string what);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("tb_top: mismatch: %s", what);
        end
    endtask

    // Advance the envelope and fade machine by one sample, return the gain
    function automatic logic [egf_pkg::DATA_W-1:0] advance_fader(
            input logic signed [egf_pkg::DATA_W-1:0] smp);
        logic [egf_pkg::CLIP_W-1:0] mag;
        logic [egf_pkg::CLIP_W-1:0] env_n;
        logic [egf_pkg::CLIP_W-1:0] thr;
        logic [63:0]                step;
        logic [egf_pkg::COEF_W-1:0] atk;
        logic [egf_pkg::COEF_W-1:0] rel;
        logic [egf_pkg::DATA_W-1:0] gain;
        mag = smp[egf_pkg::DATA_W-1] ? (egf_pkg::CLIP_W'(25'h1000000) - {1'b0, smp})
                                     : {1'b0, smp};
        atk = (cf_attack > egf_pkg::COEF_ONE) ? egf_pkg::COEF_ONE : cf_attack;
        rel = (cf_release > egf_pkg::COEF_ONE) ? egf_pkg::COEF_ONE : cf_release;
        thr = (cf_thr > egf_pkg::UNITY) ? egf_pkg::CLIP_W'(egf_pkg::UNITY)
                                        : egf_pkg::CLIP_W'(cf_thr);
        gain = egf_pkg::UNITY;

        // Envelope: attack on rise, release on fall, half-up rounding
        if (mag > egf_pkg::CLIP_W'(env_lvl)) begin
            step = (64'(atk) * 64'(mag - egf_pkg::CLIP_W'(env_lvl)) + 64'd32768) >> 16;
            env_n = egf_pkg::CLIP_W'(env_lvl) + egf_pkg::CLIP_W'(step);
        end else begin
            step = (64'(rel) * 64'(egf_pkg::CLIP_W'(env_lvl) - mag) + 64'd32768) >> 16;
            env_n = egf_pkg::CLIP_W'(env_lvl) - egf_pkg::CLIP_W'(step);
        end
        if (env_n > egf_pkg::CLIP_W'(egf_pkg::UNITY)) begin
            env_n = egf_pkg::CLIP_W'(egf_pkg::UNITY);
        end
        env_lvl = env_n[egf_pkg::DATA_W-1:0];

        case (fade_st)
            egf_pkg::FADE_CLOSED: begin
                if (env_n >= thr) begin
                    clip_lvl = thr;
                    fade_st = egf_pkg::FADE_FADING;
                end
            end
            egf_pkg::FADE_FADING: begin
                if (env_n > clip_lvl) begin
                    gain = egf_pkg::DATA_W'((64'(clip_lvl) << 23) / 64'(env_n));
                end
                if (env_n < thr) begin
                    fade_st = egf_pkg::FADE_CLOSED;
                end else begin
                    clip_lvl = clip_lvl + egf_pkg::CLIP_W'(cf_step);
                    if (clip_lvl >= egf_pkg::CLIP_W'(egf_pkg::UNITY)) begin
                        fade_st = egf_pkg::FADE_OPENED;
                    end
                end
            end
            egf_pkg::FADE_OPENED: begin
                if (env_n < thr) begin
                    fade_st = egf_pkg::FADE_CLOSED;
                end
            end
            default: ;
        endcase
        return gain;
    endfunction

    // Predict on every sample transfer
    always @(posedge clk) begin
        if (rst_n && smp_if.valid && smp_if.ready) begin
            pending_gains.push_back(advance_fader(smp_if.sample));
        end
    end

    // Compare each gain transfer with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && gain_if.valid && gain_if.ready) begin
            gains_seen++;
            if (pending_gains.size() == 0) begin
                report_error($sformatf("gain %0d: unexpected value %0d",
                                       gains_seen, gain_if.gain));
            end else begin
                oldest_gain = pending_gains.pop_front();
                if (gain_if.gain !== oldest_gain) begin
                    report_error($sformatf("gain %0d: got %0d, want %0d",
                                           gains_seen, gain_if.gain, oldest_gain));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Gain sink: random stalls, or a long hold-off when requested
    initial begin
        gain_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_left > 0) begin
                gain_if.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                gain_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one sample after random idle cycles, return once transferred
    task automatic send_sample(input logic signed [egf_pkg::DATA_W-1:0] smp);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(negedge clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample <= smp;
        do @(posedge clk); while (!smp_if.ready);
    endtask

    // Drop valid and wait until every predicted gain has arrived
    task automatic wait_idle();
        @(negedge clk);
        smp_if.valid <= 1'b0;
        while (pending_gains.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_register(input egf_pkg::t_reg_idx idx,
                                  input logic [egf_pkg::APB_DATA_W-1:0] want);
        logic [egf_pkg::APB_DATA_W-1:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= egf_pkg::APB_ADDR_W'({idx, 2'b00});
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            report_error($sformatf("register %s reads %0d, want %0d", idx.name(), got, want));
        end
    endtask

    task automatic cfg_write(input egf_pkg::t_reg_idx idx,
                             input logic [egf_pkg::APB_DATA_W-1:0] val);
        logic [egf_pkg::APB_DATA_W-1:0] kept;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= egf_pkg::APB_ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            egf_pkg::REG_ATTACK: begin
                cf_attack = val[egf_pkg::COEF_W-1:0];
                kept = egf_pkg::APB_DATA_W'(val[egf_pkg::COEF_W-1:0]);
            end
            egf_pkg::REG_RELEASE: begin
                cf_release = val[egf_pkg::COEF_W-1:0];
                kept = egf_pkg::APB_DATA_W'(val[egf_pkg::COEF_W-1:0]);
            end
            egf_pkg::REG_THRESHOLD: begin
                cf_thr = val[egf_pkg::DATA_W-1:0];
                kept = egf_pkg::APB_DATA_W'(val[egf_pkg::DATA_W-1:0]);
            end
            default: begin
                cf_step = val[egf_pkg::DATA_W-1:0];
                kept = egf_pkg::APB_DATA_W'(val[egf_pkg::DATA_W-1:0]);
            end
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        check_register(idx, kept);
    endtask

    task automatic load_settings(input logic [31:0] atk, input logic [31:0] rel,
                                 input logic [31:0] thr, input logic [31:0] stp);
        wait_idle();
        cfg_write(egf_pkg::REG_ATTACK, atk);
        cfg_write(egf_pkg::REG_RELEASE, rel);
        cfg_write(egf_pkg::REG_THRESHOLD, thr);
        cfg_write(egf_pkg::REG_CLIP_STEP, stp);
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            2: return 32'(egf_pkg::COEF_ONE);
            3: return $urandom_range(32'(egf_pkg::COEF_ONE) + 1, 131071);
            default: return $urandom_range(1000, 32'(egf_pkg::COEF_ONE));
        endcase
    endfunction

    // Bursts of loud or quiet audio with random sign, plus raw noise
    task automatic fader_traffic(input int count);
        int          sent;
        int          kind;
        int          len;
        int unsigned level;
        int unsigned mag;
        logic signed [egf_pkg::DATA_W-1:0] smp;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(9);
            len = $urandom_range(1, 24);
            level = (kind < 5) ? $urandom_range(2000000, 8388607) : $urandom_range(0, 300000);
            for (int i = 0; i < len && sent < count; i++) begin
                if (kind >= 8) begin
                    smp = egf_pkg::DATA_W'($urandom());
                end else begin
                    mag = level - $urandom_range(0, level >> 3);
                    smp = egf_pkg::DATA_W'(mag);
                    if ($urandom_range(1)) begin
                        smp = -smp;
                    end
                end
                send_sample(smp);
                sent++;
            end
        end
    endtask

    task automatic test_register_access();
        check_register(egf_pkg::REG_ATTACK, egf_pkg::APB_DATA_W'(egf_pkg::ATTACK_RST));
        check_register(egf_pkg::REG_RELEASE, egf_pkg::APB_DATA_W'(egf_pkg::RELEASE_RST));
        check_register(egf_pkg::REG_THRESHOLD, egf_pkg::APB_DATA_W'(egf_pkg::THRESHOLD_RST));
        check_register(egf_pkg::REG_CLIP_STEP, egf_pkg::APB_DATA_W'(egf_pkg::CLIP_STEP_RST));
    endtask

    task automatic test_field_extremes();
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'hFFFFFF);
        send_sample(24'h000001);
        send_sample(24'h555555);
        wait_idle();
    endtask

    task automatic test_special_cases();
        // coefficient and threshold above unity, clip overflow into opened
        load_settings(131071, 32'(egf_pkg::COEF_ONE), 32'hFFFFFF, 32'hFFFFFF);
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        // zero coefficients hold the envelope, zero threshold never closes
        load_settings(0, 0, 0, 0);
        send_sample(24'h7FFFFF);
        send_sample(24'h000064);
        load_settings(32'(egf_pkg::COEF_ONE), 0, 0, 0);
        send_sample(24'h3D0900);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        wait_idle();
    endtask

    task automatic test_fade_ramp();
        load_settings(32768, 4096, 100000, 20000);
        repeat (5) send_sample(24'h7FFFFF);
        repeat (2) send_sample(24'h000000);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int          tx_pcts[4];
        int          rx_pcts[4];
        logic [31:0] thr;
        logic [31:0] stp;
        tx_pcts = '{0, 86, 0, 32};
        rx_pcts = '{0, 0, 86, 32};
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct = tx_pcts[p];
            rx_stall_pct = rx_pcts[p];
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(7))
                    0: thr = 0;
                    1: thr = 32'(egf_pkg::UNITY);
                    2: thr = $urandom_range(32'(egf_pkg::UNITY) + 1, 32'hFFFFFF);
                    default: thr = $urandom_range(1, 6000000);
                endcase
                case ($urandom_range(7))
                    0: stp = 0;
                    1: stp = $urandom_range(1, 32'hFFFFFF);
                    default: stp = $urandom_range(1, 300000);
                endcase
                load_settings(pick_coef(), pick_coef(), thr, stp);
                fader_traffic(110);
            end
        end
    endtask

    // Hold the sink off while samples keep coming, so the input stalls
    task automatic test_output_backpressure();
        load_settings(20000, 3000, 500000, 10000);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        @(posedge clk);
        rx_hold_req = HOLD_CYCLES;
        fader_traffic(12);
        wait_idle();
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 32;
        rx_stall_pct = 32;
        fader_traffic(15);
        wait_idle();
        fader_traffic(15);
        wait_idle();
    endtask

    initial begin
        smp_if.valid = 1'b0;
        smp_if.sample = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_field_extremes();
        test_special_cases();
        test_fade_ramp();
        test_output_backpressure();
        test_drain_pause();
        test_random_traffic();

        wait_idle();
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ envelope_gated_gain_fader_unit.f @@
+incdir+hw/rtl
hw/rtl/egf_pkg.sv
hw/rtl/egf_stream_if.sv
hw/rtl/egf_regs.sv
hw/rtl/egf_mul.sv
hw/rtl/egf_div.sv
hw/rtl/envelope_gated_gain_fader_unit.sv
tb/tb_top.sv
